[src/psf2_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the psf2 unicode table parser
// no dependencies

package psf2_pkg;

    // special table bytes
    localparam logic [7:0] SEPARATOR_BYTE  = 8'hFE;
    localparam logic [7:0] TERMINATOR_BYTE = 8'hFF;

    localparam logic [7:0]  POINT_MAX = 8'hFF;
    localparam logic [7:0]  ALT_MAX   = 8'hFF;
    localparam logic [15:0] GLYPH_MAX = 16'hFFFF;

    // result kinds
    typedef enum logic [2:0] {
        KIND_POINT     = 3'd0,
        KIND_SEQ_END   = 3'd1,
        KIND_GLYPH_END = 3'd2,
        KIND_MALFORMED = 3'd3,
        KIND_TRUNCATED = 3'd4
    } t_kind;

    // one input request
    typedef struct packed {
        logic [7:0] table_byte;
        logic       is_last;
    } t_in_req;

    // one result
    typedef struct packed {
        t_kind       kind;
        logic [20:0] code_point;
        logic [15:0] glyph_index;
        logic [7:0]  sequence_number;
        logic [7:0]  position;
    } t_out_res;

    // parser state
    typedef struct packed {
        logic [15:0] glyph_counter;
        logic [7:0]  alternate_counter;
        logic [7:0]  point_counter;
        logic [20:0] point_accumulator;
        logic [1:0]  bytes_pending;
    } t_state;

endpackage

[src/psf2_decode.sv]
`timescale 1ns / 1ps
// per-byte utf-8 decode and sequence bookkeeping with its state registers
// depends on psf2_pkg

module psf2_decode import psf2_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_step,
    input  t_in_req  i_req,
    output logic     o_emit,
    output t_out_res o_res,
    output t_state   o_state
);

    t_state r_st;
    t_state n_st;
    logic [7:0]  b;
    logic [20:0] acc_shift;
    logic [1:0]  pend_dec;
    logic [7:0]  pc_inc;
    logic [7:0]  alt_inc;
    logic [15:0] glyph_inc;

    assign b         = i_req.table_byte;
    assign acc_shift = {r_st.point_accumulator[14:0], b[5:0]};
    assign pend_dec  = r_st.bytes_pending - 2'd1;

    // saturating increments
    assign pc_inc    = (r_st.point_counter == POINT_MAX) ? POINT_MAX
                     : r_st.point_counter + 8'd1;
    assign alt_inc   = (r_st.alternate_counter == ALT_MAX) ? ALT_MAX
                     : r_st.alternate_counter + 8'd1;
    assign glyph_inc = (r_st.glyph_counter == GLYPH_MAX) ? GLYPH_MAX
                     : r_st.glyph_counter + 16'd1;

    // next state and result
    always_comb begin
        n_st                  = r_st;
        o_emit                = 1'b0;
        o_res.kind            = KIND_POINT;
        o_res.code_point      = '0;
        o_res.glyph_index     = r_st.glyph_counter;
        o_res.sequence_number = r_st.alternate_counter;
        o_res.position        = r_st.point_counter;
        if (i_req.is_last) begin
            o_emit     = 1'b1;
            o_res.kind = (r_st.bytes_pending == 2'd0 && b == TERMINATOR_BYTE)
                       ? KIND_GLYPH_END : KIND_TRUNCATED;
            n_st       = '0;
        end else if (r_st.bytes_pending != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                n_st.bytes_pending = pend_dec;
                if (pend_dec == 2'd0) begin
                    o_emit                 = 1'b1;
                    o_res.code_point       = acc_shift;
                    n_st.point_counter     = pc_inc;
                    n_st.point_accumulator = '0;
                end else begin
                    n_st.point_accumulator = acc_shift;
                end
            end else begin
                // open code point broken by a non-continuation byte
                o_emit                 = 1'b1;
                o_res.kind             = KIND_MALFORMED;
                n_st.bytes_pending     = 2'd0;
                n_st.point_accumulator = '0;
            end
        end else if (b == SEPARATOR_BYTE) begin
            o_emit                 = 1'b1;
            o_res.kind             = KIND_SEQ_END;
            n_st.alternate_counter = alt_inc;
            n_st.point_counter     = '0;
        end else if (b == TERMINATOR_BYTE) begin
            o_emit                 = 1'b1;
            o_res.kind             = KIND_GLYPH_END;
            n_st.glyph_counter     = glyph_inc;
            n_st.alternate_counter = '0;
            n_st.point_counter     = '0;
        end else if (b[7] == 1'b0) begin
            o_emit             = 1'b1;
            o_res.code_point   = {13'd0, b};
            n_st.point_counter = pc_inc;
        end else if (b[7:5] == 3'b110) begin
            n_st.point_accumulator = {16'd0, b[4:0]};
            n_st.bytes_pending     = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            n_st.point_accumulator = {17'd0, b[3:0]};
            n_st.bytes_pending     = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            n_st.point_accumulator = {18'd0, b[2:0]};
            n_st.bytes_pending     = 2'd3;
        end else begin
            // stray continuation or invalid lead byte
            o_emit     = 1'b1;
            o_res.kind = KIND_MALFORMED;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_state = r_st;

endmodule

[src/psf2_unicode_table_parser_unit.sv]
`timescale 1ns / 1ps
// top level of the psf2 unicode table parser: input and result registers
// depends on psf2_pkg and psf2_decode

// Takes one table byte per cycle when not stalled and gives at most one result
// per byte. A byte is held in the input register, is decoded against the
// parser state and lands in the result register. The decode path from input
// register to result register is a single short pass of byte compares and
// saturating counter increments, which sets the one-byte-per-cycle rate; a
// stall on the result side holds the input register, and the input side
// stalls only when that register is full and cannot move on.

module psf2_unicode_table_parser_unit import psf2_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_data
);

    logic     r_in_valid;
    t_in_req  r_in;
    logic     r_out_valid;
    t_out_res r_out;
    logic     can_take;
    logic     step;
    logic     emit;
    t_out_res res;
    t_state   st;

    // result register can load when empty or being drained
    assign can_take   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && can_take;
    assign o_in_stall = r_in_valid && !can_take;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    psf2_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in),
        .o_emit  (emit),
        .o_res   (res),
        .o_state (st)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_take) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a last byte leaves the parser fully reset
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && r_in.is_last |=> st == '0)
        else $error("state not cleared after last byte");

    // an emitting step always shows up as a result
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && emit |=> o_out_valid)
        else $error("emitted result lost");

    // input side only stalls while holding a byte
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && o_out_valid && i_out_stall)
        else $error("input stalled without cause");

    // code points only ever come with kind point
    a_cp_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_POINT |-> o_out_data.code_point == '0)
        else $error("code point on non-point result");

endmodule

[tb/psf2_unicode_table_parser_unit_tb.sv]
`timescale 1ns / 1ps
// testbench for psf2_unicode_table_parser_unit: directed and random table bytes,
// an in-bench parser that predicts every result, and random idling on both sides
// depends on psf2_pkg and the parser rtl

module psf2_unicode_table_parser_unit_tb;
    import psf2_pkg::*;

    localparam int TABLE_BYTES = 1450;
    localparam int DRAIN_CYCLES = 8;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     in_valid = 1'b0;
    t_in_req  in_data = '0;
    logic     out_stall = 1'b0;
    logic     o_in_stall;
    logic     o_out_valid;
    t_out_res o_out_data;

    // table bytes waiting to be sent, predicted results waiting to arrive
    t_in_req  byte_q[$];
    t_out_res result_q[$];

    // predicted parser state
    logic [15:0] glyph_cnt = '0;
    logic [7:0]  alt_cnt = '0;
    logic [7:0]  point_cnt = '0;
    logic [20:0] point_acc = '0;
    logic [1:0]  cont_left = '0;

    int errors = 0;
    int bytes_sent = 0;
    int results_seen = 0;
    int kind_seen[5] = '{default: 0};
    int in_gap = 0;
    int stall_left = 0;
    bit quiet_in = 1'b0;
    bit quiet_out = 1'b0;

    psf2_unicode_table_parser_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // parser prediction
    // ---------------------------------------------------------------

    function automatic logic [7:0] sat8(input logic [7:0] v);
        return (v == POINT_MAX) ? v : v + 8'd1;
    endfunction

    task automatic push_result(input t_kind k, input logic [20:0] cp,
                               input logic [7:0] pos);
        t_out_res r;
        r.kind            = k;
        r.code_point      = cp;
        r.glyph_index     = glyph_cnt;
        r.sequence_number = alt_cnt;
        r.position        = pos;
        result_q.push_back(r);
    endtask

    task automatic clear_parser();
        glyph_cnt = '0;
        alt_cnt   = '0;
        point_cnt = '0;
        point_acc = '0;
        cont_left = '0;
    endtask

    task automatic parse_byte(input t_in_req req);
        logic [7:0] b;
        b = req.table_byte;
        if (req.is_last) begin
            // last byte: only a clean terminator closes the table
            if (cont_left == 0 && b == TERMINATOR_BYTE)
                push_result(KIND_GLYPH_END, '0, point_cnt);
            else
                push_result(KIND_TRUNCATED, '0, point_cnt);
            clear_parser();
        end else if (cont_left != 0) begin
            // code point open: expect continuation bytes
            if (b[7:6] == 2'b10) begin
                point_acc = {point_acc[14:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 0) begin
                    push_result(KIND_POINT, point_acc, point_cnt);
                    point_cnt = sat8(point_cnt);
                    point_acc = '0;
                end
            end else begin
                cont_left = '0;
                point_acc = '0;
                push_result(KIND_MALFORMED, '0, point_cnt);
            end
        end else if (b == SEPARATOR_BYTE) begin
            push_result(KIND_SEQ_END, '0, point_cnt);
            alt_cnt   = (alt_cnt == ALT_MAX) ? alt_cnt : alt_cnt + 8'd1;
            point_cnt = '0;
        end else if (b == TERMINATOR_BYTE) begin
            push_result(KIND_GLYPH_END, '0, point_cnt);
            glyph_cnt = (glyph_cnt == GLYPH_MAX) ? glyph_cnt : glyph_cnt + 16'd1;
            alt_cnt   = '0;
            point_cnt = '0;
        end else if (b[7] == 1'b0) begin
            push_result(KIND_POINT, {13'd0, b}, point_cnt);
            point_cnt = sat8(point_cnt);
        end else if (b[7:5] == 3'b110) begin
            point_acc = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            point_acc = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
            point_acc = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end else begin
            // stray continuation or invalid lead
            push_result(KIND_MALFORMED, '0, point_cnt);
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    task automatic add_byte(input logic [7:0] b, input logic last);
        t_in_req req;
        req.table_byte = b;
        req.is_last    = last;
        byte_q.push_back(req);
    endtask

    // utf-8 encode a random code point of 1 to 4 bytes, overlong forms allowed
    task automatic add_point();
        int          n;
        logic [20:0] cp;
        n  = $urandom_range(1, 4);
        cp = 21'($urandom);
        case (n)
            1: begin
                add_byte({1'b0, cp[6:0]}, 1'b0);
            end
            2: begin
                add_byte({3'b110, cp[10:6]}, 1'b0);
                add_byte({2'b10, cp[5:0]}, 1'b0);
            end
            3: begin
                add_byte({4'b1110, cp[15:12]}, 1'b0);
                add_byte({2'b10, cp[11:6]}, 1'b0);
                add_byte({2'b10, cp[5:0]}, 1'b0);
            end
            default: begin
                add_byte({5'b11110, cp[20:18]}, 1'b0);
                add_byte({2'b10, cp[17:12]}, 1'b0);
                add_byte({2'b10, cp[11:6]}, 1'b0);
                add_byte({2'b10, cp[5:0]}, 1'b0);
            end
        endcase
    endtask

    task automatic build_directed();
        // ascii extremes
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b0);
        // smallest two-byte form, largest three-byte and four-byte forms
        add_byte(8'hC2, 1'b0); add_byte(8'h80, 1'b0);
        add_byte(8'hEF, 1'b0); add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'hF7, 1'b0); add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0); add_byte(8'hBF, 1'b0);
        // separator
        add_byte(SEPARATOR_BYTE, 1'b0);
        // stray continuation and invalid leads
        add_byte(8'h80, 1'b0);
        add_byte(8'hF8, 1'b0);
        add_byte(8'hFD, 1'b0);
        // open code point broken by ascii, then by a separator
        add_byte(8'hC3, 1'b0); add_byte(8'h41, 1'b0);
        add_byte(8'hE0, 1'b0); add_byte(SEPARATOR_BYTE, 1'b0);
        // terminator
        add_byte(TERMINATOR_BYTE, 1'b0);
        // terminator flagged last while a code point is open
        add_byte(8'hF0, 1'b0); add_byte(8'h90, 1'b0);
        add_byte(TERMINATOR_BYTE, 1'b1);
        // last byte that is not a terminator, then a clean end
        add_byte(8'h41, 1'b1);
        add_byte(TERMINATOR_BYTE, 1'b1);
    endtask

    task automatic build_random();
        int         r;
        int         n;
        int         k;
        logic [7:0] b;
        bit         long_seq_done;
        bit         long_alt_done;
        long_seq_done = 1'b0;
        long_alt_done = 1'b0;
        while (byte_q.size() < TABLE_BYTES) begin
            r = $urandom_range(0, 99);
            if (!long_seq_done && byte_q.size() > 300) begin
                // one long sequence drives the point counter into saturation
                repeat (262) add_byte(8'($urandom_range(0, 127)), 1'b0);
                add_byte(TERMINATOR_BYTE, 1'b0);
                long_seq_done = 1'b1;
            end else if (!long_alt_done && byte_q.size() > 800) begin
                // many alternates drive the sequence counter into saturation
                repeat (260) add_byte(SEPARATOR_BYTE, 1'b0);
                add_point();
                add_byte(TERMINATOR_BYTE, 1'b0);
                long_alt_done = 1'b1;
            end else if (r < 70) begin
                // well-formed glyph entry
                n = $urandom_range(1, 4);
                for (int s = 0; s < n; s++) begin
                    if (s != 0)
                        add_byte(SEPARATOR_BYTE, 1'b0);
                    k = $urandom_range(0, 5);
                    repeat (k) add_point();
                end
                add_byte(TERMINATOR_BYTE, ($urandom_range(0, 19) == 0));
            end else if (r < 80) begin
                // raw noise
                n = $urandom_range(1, 6);
                repeat (n) add_byte(8'($urandom_range(0, 255)),
                                    ($urandom_range(0, 39) == 0));
            end else if (r < 92) begin
                // code point cut short by a non-continuation byte
                n = $urandom_range(2, 4);
                case (n)
                    2: add_byte({3'b110, 5'($urandom)}, 1'b0);
                    3: add_byte({4'b1110, 4'($urandom)}, 1'b0);
                    default: add_byte({5'b11110, 3'($urandom)}, 1'b0);
                endcase
                k = $urandom_range(0, n - 2);
                repeat (k) add_byte({2'b10, 6'($urandom)}, 1'b0);
                b = 8'($urandom_range(0, 255));
                if (b[7:6] == 2'b10)
                    b[6] = 1'b1;
                add_byte(b, 1'b0);
            end else begin
                // table cut off before its terminator
                k = $urandom_range(0, 3);
                repeat (k) add_point();
                add_byte(8'($urandom_range(0, 254)), 1'b1);
            end
        end
    endtask

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ---------------------------------------------------------------
    // driver: request side
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            // request accepted: predict its result
            if (in_valid && !o_in_stall) begin
                parse_byte(in_data);
                bytes_sent++;
                if ($urandom_range(0, 149) == 0)
                    quiet_in = !quiet_in;
            end
            // present the next request or idle
            if (!in_valid || !o_in_stall) begin
                if (in_gap > 0) begin
                    in_valid <= 1'b0;
                    in_gap--;
                end else if (byte_q.size() > 0) begin
                    in_valid <= 1'b1;
                    in_data  <= byte_q.pop_front();
                    in_gap   = pick_gap(quiet_in);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: result side
    // ---------------------------------------------------------------

    task automatic report_field(input string fname, input logic [20:0] want,
                                input logic [20:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, fname, want, got);
        errors++;
    endtask

    always @(posedge i_clk) begin
        t_out_res want;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            // compare accepted result with the oldest prediction
            if (o_out_valid && !out_stall) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d cp 0x%0h",
                             $time, o_out_data.kind, o_out_data.code_point);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    kind_seen[want.kind]++;
                    if (o_out_data.kind !== want.kind)
                        report_field("kind", 21'(want.kind), 21'(o_out_data.kind));
                    if (o_out_data.code_point !== want.code_point)
                        report_field("code_point", want.code_point, o_out_data.code_point);
                    if (o_out_data.glyph_index !== want.glyph_index)
                        report_field("glyph_index", 21'(want.glyph_index),
                                     21'(o_out_data.glyph_index));
                    if (o_out_data.sequence_number !== want.sequence_number)
                        report_field("sequence_number", 21'(want.sequence_number),
                                     21'(o_out_data.sequence_number));
                    if (o_out_data.position !== want.position)
                        report_field("position", 21'(want.position),
                                     21'(o_out_data.position));
                end
            end
            // random back-pressure in runs
            if ($urandom_range(0, 299) == 0)
                quiet_out = !quiet_out;
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (!quiet_out && $urandom_range(0, 3) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                            : $urandom_range(1, 3);
            end
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------

    initial begin
        build_directed();
        build_random();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all requests out, then all predictions met, then a short drain
        while (byte_q.size() != 0 || in_valid)
            @(posedge i_clk);
        while (result_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d table bytes with random gaps and back-pressure, %0d results checked",
                 bytes_sent, results_seen);
        $display("by kind: points %0d, sequence ends %0d, glyph ends %0d",
                 kind_seen[KIND_POINT], kind_seen[KIND_SEQ_END], kind_seen[KIND_GLYPH_END]);
        $display("         malformed %0d, truncated %0d",
                 kind_seen[KIND_MALFORMED], kind_seen[KIND_TRUNCATED]);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("%0t: timeout, %0d results still expected", $time, result_q.size());
        $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
src/psf2_pkg.sv
src/psf2_decode.sv
src/psf2_unicode_table_parser_unit.sv
tb/psf2_unicode_table_parser_unit_tb.sv
